// File: rtl/mexp_pkg.sv
package mexp_pkg;

  localparam int unsigned OpWidth = 31;
  localparam int unsigned CntWidth = $clog2(OpWidth);
  localparam int unsigned PcWidth = 4;

  typedef logic [OpWidth-1:0] operand_t;
  typedef logic [CntWidth-1:0] cnt_t;
  typedef logic [PcWidth-1:0] pc_t;

  typedef struct packed {
    logic [OpWidth-1:0] base_value;
    logic [OpWidth-1:0] exponent_value;
    logic [OpWidth-1:0] modulus_value;
  } mexp_req_t;

  typedef struct packed {
    logic [OpWidth-1:0] power_result;
    logic               zero_modulus_error;
  } mexp_rsp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ACC_ONE,
    OP_MUL_START,
    OP_MUL_WAIT,
    OP_EXP_NEXT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_M_ZERO,
    C_MUL_BUSY,
    C_EBIT_CLR,
    C_EXP_MORE,
    C_OUT_BUSY
  } cond_e;

  // multiplier operand y; operand x is always the accumulator
  typedef enum logic {
    SRC_BASE,
    SRC_ACC
  } src_e;

  typedef enum logic {
    DST_BASE,
    DST_ACC
  } dst_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    src_e  src;
    dst_e  dst;
    logic  in_rdy;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic m_zero;
    logic mul_done;
    logic e_msb;
    logic exp_more;
    logic out_free;
  } ucond_t;

  localparam pc_t StWait    = pc_t'(0);
  localparam pc_t StInit    = pc_t'(1);
  localparam pc_t StRedGo   = pc_t'(2);
  localparam pc_t StRedWait = pc_t'(3);
  localparam pc_t StSqGo    = pc_t'(4);
  localparam pc_t StSqWait  = pc_t'(5);
  localparam pc_t StTest    = pc_t'(6);
  localparam pc_t StMulGo   = pc_t'(7);
  localparam pc_t StMulWait = pc_t'(8);
  localparam pc_t StNext    = pc_t'(9);
  localparam pc_t StEmit    = pc_t'(10);
  localparam pc_t StReturn  = pc_t'(11);

  // Branch taken: go to target; otherwise fall through to the next step.
  function automatic uword_t mexp_ucode(pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, src: SRC_BASE, dst: DST_ACC,
          in_rdy: 1'b0, target: StWait};
    case (pc)
      StWait: begin
        w.op = OP_LOAD; w.in_rdy = 1'b1; w.cond = C_NO_INPUT; w.target = StWait;
      end
      StInit: begin
        w.op = OP_ACC_ONE; w.cond = C_M_ZERO; w.target = StEmit;
      end
      // base mod m as (1 mod m) * base
      StRedGo: begin
        w.op = OP_MUL_START; w.src = SRC_BASE; w.cond = C_NEVER;
      end
      StRedWait: begin
        w.op = OP_MUL_WAIT; w.dst = DST_BASE; w.cond = C_MUL_BUSY; w.target = StRedWait;
      end
      StSqGo: begin
        w.op = OP_MUL_START; w.src = SRC_ACC; w.cond = C_NEVER;
      end
      StSqWait: begin
        w.op = OP_MUL_WAIT; w.dst = DST_ACC; w.cond = C_MUL_BUSY; w.target = StSqWait;
      end
      StTest: begin
        w.cond = C_EBIT_CLR; w.target = StNext;
      end
      StMulGo: begin
        w.op = OP_MUL_START; w.src = SRC_BASE; w.cond = C_NEVER;
      end
      StMulWait: begin
        w.op = OP_MUL_WAIT; w.dst = DST_ACC; w.cond = C_MUL_BUSY; w.target = StMulWait;
      end
      StNext: begin
        w.op = OP_EXP_NEXT; w.cond = C_EXP_MORE; w.target = StSqGo;
      end
      StEmit: begin
        w.op = OP_EMIT; w.cond = C_OUT_BUSY; w.target = StEmit;
      end
      StReturn: begin
        w.cond = C_ALWAYS; w.target = StWait;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = StWait;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/mexp_mulmod.sv
module mexp_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  mexp_pkg::operand_t        x_i,
  input  mexp_pkg::operand_t        y_i,
  input  mexp_pkg::operand_t        m_i,
  output logic                      done_o,
  output mexp_pkg::operand_t        prod_o
);
  import mexp_pkg::*;

  localparam int unsigned SumWidth = OpWidth + 3;

  operand_t acc_q, acc_d;
  operand_t x_q, x_d;
  operand_t y_q, y_d;
  cnt_t     cnt_q, cnt_d;
  logic     busy_q, busy_d;
  logic     done_q, done_d;

  logic [SumWidth-1:0] sum0, sum1, sum2;
  logic [SumWidth-1:0] m_ext, m2_ext;

  // 2*acc + bit*x stays below 3m: subtract 0, m or 2m in parallel
  always_comb begin
    m_ext  = SumWidth'(m_i);
    m2_ext = SumWidth'({m_i, 1'b0});
    sum0   = SumWidth'({acc_q, 1'b0}) + (y_q[OpWidth-1] ? SumWidth'(x_q) : '0);
    sum1   = sum0 - m_ext;
    sum2   = sum0 - m2_ext;
  end

  always_comb begin
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
      cnt_d  = cnt_t'(OpWidth - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sum2[SumWidth-1]) begin
        acc_d = sum2[OpWidth-1:0];
      end else if (!sum1[SumWidth-1]) begin
        acc_d = sum1[OpWidth-1:0];
      end else begin
        acc_d = sum0[OpWidth-1:0];
      end
      y_d = {y_q[OpWidth-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/mexp_sequencer.sv
module mexp_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mexp_pkg::ucond_t  cond_i,
  output mexp_pkg::uword_t  uword_o
);
  import mexp_pkg::*;

  pc_t    pc_q, pc_d;
  uword_t word;
  logic   taken;

  always_comb begin
    word = mexp_ucode(pc_q);
    case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_INPUT: taken = !cond_i.in_valid;
      C_M_ZERO:   taken = cond_i.m_zero;
      C_MUL_BUSY: taken = !cond_i.mul_done;
      C_EBIT_CLR: taken = !cond_i.e_msb;
      C_EXP_MORE: taken = cond_i.exp_more;
      C_OUT_BUSY: taken = !cond_i.out_free;
      default:    taken = 1'b0;
    endcase
    pc_d = taken ? word.target : pc_q + pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = word;

endmodule

// File: rtl/modular_exponentiation_unit.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_ready_o  in_req_i   (base, exponent, modulus)
// result    out        out_valid_o / out_ready_i out_rsp_o (power, zero-modulus flag)
//
// One request at a time. Each modular multiply runs in the
// bit-serial add-and-reduce unit; a zero modulus skips the multiplies.
// Reset puts the microcode step counter at the request wait step.
// The result register holds until taken; a finished result waits in the emit step while it is still full.
module modular_exponentiation_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mexp_pkg::mexp_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mexp_pkg::mexp_rsp_t out_rsp_o
);
  import mexp_pkg::*;

  uword_t    uword;
  ucond_t    ucond;

  operand_t  acc_q, acc_d;
  operand_t  base_q, base_d;
  operand_t  exp_q, exp_d;
  operand_t  mod_q, mod_d;
  logic      err_q, err_d;
  cnt_t      ecnt_q, ecnt_d;
  logic      out_valid_q, out_valid_d;
  mexp_rsp_t out_rsp_q, out_rsp_d;

  logic      mul_start;
  logic      mul_done;
  operand_t  mul_y;
  operand_t  mul_prod;
  logic      out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ucond.in_valid = in_valid_i;
    ucond.m_zero   = (mod_q == '0);
    ucond.mul_done = mul_done;
    ucond.e_msb    = exp_q[OpWidth-1];
    ucond.exp_more = (ecnt_q != '0);
    ucond.out_free = out_free;
  end

  mexp_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cond_i  (ucond),
    .uword_o (uword)
  );

  assign mul_start = (uword.op == OP_MUL_START);
  assign mul_y     = (uword.src == SRC_ACC) ? acc_q : base_q;

  mexp_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (acc_q),
    .y_i     (mul_y),
    .m_i     (mod_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign in_ready_o = uword.in_rdy;

  always_comb begin
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    err_d       = err_q;
    ecnt_d      = ecnt_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (uword.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          base_d = in_req_i.base_value;
          exp_d  = in_req_i.exponent_value;
          mod_d  = in_req_i.modulus_value;
          err_d  = (in_req_i.modulus_value == '0);
          ecnt_d = cnt_t'(OpWidth - 1);
        end
      end
      OP_ACC_ONE: begin
        // 1 mod m, and 0 for the error case
        acc_d    = '0;
        acc_d[0] = (mod_q > operand_t'(1));
      end
      OP_MUL_WAIT: begin
        if (mul_done) begin
          if (uword.dst == DST_BASE) begin
            base_d = mul_prod;
          end else begin
            acc_d = mul_prod;
          end
        end
      end
      OP_EXP_NEXT: begin
        exp_d  = {exp_q[OpWidth-2:0], 1'b0};
        ecnt_d = ecnt_q - cnt_t'(1);
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d                  = 1'b1;
          out_rsp_d.power_result       = acc_q;
          out_rsp_d.zero_modulus_error = err_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ecnt_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      ecnt_q      <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    base_q    <= base_d;
    exp_q     <= exp_d;
    mod_q     <= mod_d;
    err_q     <= err_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: dv/mexp_result_checker.sv
module mexp_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  mexp_pkg::mexp_req_t req_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  mexp_pkg::mexp_rsp_t rsp_i,
  output int                  pending_o,
  output int                  mismatches_o
);
  import mexp_pkg::*;

  typedef struct packed {
    mexp_req_t req;
    mexp_rsp_t rsp;
  } power_job_t;

  power_job_t powers_due[$];
  int         mismatches = 0;

  assign mismatches_o = mismatches;

  // square-and-multiply from the top exponent bit; 64-bit products never wrap
  function automatic mexp_rsp_t expected_power(mexp_req_t req);
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] acc;
    mexp_rsp_t   rsp;
    rsp = '0;
    m   = 64'(req.modulus_value);
    if (m == 64'd0) begin
      rsp.zero_modulus_error = 1'b1;
    end else begin
      b   = 64'(req.base_value) % m;
      acc = 64'd1 % m;
      for (int i = OpWidth - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (req.exponent_value[i]) begin
          acc = (acc * b) % m;
        end
      end
      rsp.power_result = operand_t'(acc);
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    power_job_t job;
    if (!rst_ni) begin
      powers_due.delete();
      pending_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (powers_due.size() == 0) begin
          report_mismatch($sformatf("result %0d (err %0b) with no request pending",
                                    rsp_i.power_result, rsp_i.zero_modulus_error));
        end else begin
          job = powers_due.pop_front();
          if (rsp_i.power_result !== job.rsp.power_result) begin
            report_mismatch($sformatf("%0d^%0d mod %0d: power %0d, want %0d",
                                      job.req.base_value, job.req.exponent_value,
                                      job.req.modulus_value, rsp_i.power_result,
                                      job.rsp.power_result));
          end
          if (rsp_i.zero_modulus_error !== job.rsp.zero_modulus_error) begin
            report_mismatch($sformatf("%0d^%0d mod %0d: error flag %0b, want %0b",
                                      job.req.base_value, job.req.exponent_value,
                                      job.req.modulus_value, rsp_i.zero_modulus_error,
                                      job.rsp.zero_modulus_error));
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        job.req = req_i;
        job.rsp = expected_power(req_i);
        powers_due.insert(powers_due.size(), job);
      end
      pending_o <= powers_due.size();
    end
  end

endmodule

// File: dv/modular_exponentiation_unit_tb.sv
module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  localparam int unsigned RandomRequests = 272;
  localparam int unsigned HoldOffCycles  = 6000;
  localparam int unsigned DrainCycles    = 2200;
  localparam int unsigned CycleLimit     = 4_000_000;
  localparam operand_t    OpMax          = '1;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  mexp_req_t in_req    = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mexp_rsp_t out_rsp;

  logic        steady   = 1'b0;
  logic        hold_req = 1'b0;
  int          pending;
  int          fail_count;
  int unsigned cycle_count = 0;

  modular_exponentiation_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  mexp_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (in_valid),
    .req_ready_i (in_ready),
    .req_i       (in_req),
    .rsp_valid_i (out_valid),
    .rsp_ready_i (out_ready),
    .rsp_i       (out_rsp),
    .pending_o   (pending),
    .mismatches_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: random back-pressure unless steady, one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  function automatic mexp_req_t make_req(operand_t b, operand_t e, operand_t m);
    mexp_req_t r;
    r.base_value     = b;
    r.exponent_value = e;
    r.modulus_value  = m;
    return r;
  endfunction

  function automatic operand_t near_max();
    return OpMax - operand_t'($urandom_range(0, 7));
  endfunction

  function automatic mexp_req_t random_request();
    operand_t b;
    operand_t e;
    operand_t m;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4)       m = '0;
    else if (pick < 20) m = operand_t'($urandom_range(1, 16));
    else if (pick < 26) m = near_max();
    else                m = operand_t'($urandom());
    pick = $urandom_range(99);
    if (pick < 10)      b = operand_t'($urandom_range(0, 3));
    else if (pick < 20) b = near_max();
    else                b = operand_t'($urandom());
    pick = $urandom_range(99);
    if (pick < 10)      e = operand_t'($urandom_range(0, 3));
    else if (pick < 15) e = OpMax;
    else                e = operand_t'($urandom());
    return make_req(b, e, m);
  endfunction

  // returns at the edge where the request was taken; valid stays high
  task automatic send_request(input mexp_req_t r, input bit may_idle);
    if (may_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      if ($urandom_range(19) == 0) repeat ($urandom_range(200, 1500)) @(posedge clk);
      else repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    bit quiet;
    quiet = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero modulus
    send_request(make_req(operand_t'(5), operand_t'(3), '0), 1'b1);
    send_request(make_req(OpMax, OpMax, '0), 1'b1);
    // modulus one, with and without exponent
    send_request(make_req(operand_t'(9), '0, operand_t'(1)), 1'b1);
    send_request(make_req(OpMax, OpMax, operand_t'(1)), 1'b1);
    // zero exponent, zero base
    send_request(make_req(operand_t'(5), '0, operand_t'(7)), 1'b1);
    send_request(make_req('0, operand_t'(5), operand_t'(13)), 1'b1);
    send_request(make_req('0, '0, operand_t'(13)), 1'b1);
    send_request(make_req('0, OpMax, OpMax), 1'b1);
    // extremes
    send_request(make_req(OpMax, OpMax, OpMax), 1'b1);
    send_request(make_req(OpMax, OpMax, OpMax - operand_t'(1)), 1'b1);
    send_request(make_req(OpMax - operand_t'(1), OpMax - operand_t'(1),
                          operand_t'(2147483629)), 1'b1);
    send_request(make_req(operand_t'(2), operand_t'(30), OpMax), 1'b1);
    send_request(make_req(operand_t'(1000), operand_t'(3), operand_t'(7)), 1'b1);
    send_request(make_req(operand_t'(123456789), operand_t'(1), operand_t'(1000)), 1'b1);
    send_request(make_req(operand_t'(7), operand_t'(9), operand_t'(2)), 1'b1);
    // products past 31 bits
    send_request(make_req(operand_t'(46348), operand_t'(2), operand_t'(46349)), 1'b1);
    send_request(make_req(operand_t'(31'h2AAAAAAA), operand_t'(31'h55555555),
                          operand_t'(31'h55555555)), 1'b1);
    send_request(make_req(operand_t'(31'h55555555), operand_t'(31'h2AAAAAAA),
                          operand_t'(31'h2AAAAAAA)), 1'b1);
    send_request(make_req(operand_t'(31'h40000000), OpMax, operand_t'(31'h40000001)), 1'b1);

    // pause the sender until the directed requests are all answered
    in_valid <= 1'b0;
    wait_for_results();

    for (int n = 0; n < RandomRequests; n++) begin
      if (n == 40) hold_req <= 1'b1;
      if (n == 110) begin
        quiet = 1'b1;
        steady <= 1'b1;
      end
      if (n == 150) begin
        quiet = 1'b0;
        steady <= 1'b0;
      end
      if (n == 200) begin
        in_valid <= 1'b0;
        wait_for_results();
      end
      send_request(random_request(), !quiet);
    end

    in_valid <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: modular_exponentiation_unit.f
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_sequencer.sv
rtl/modular_exponentiation_unit.sv
dv/mexp_result_checker.sv
dv/modular_exponentiation_unit_tb.sv
